/* rtl/wsmc_pkg.sv */
`timescale 1ns / 1ps

package wsmc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_TEMP  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRS_A = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRS_B = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRS_C = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM   = 3'd4;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_PDIV, ST_PQ,
        ST_P9, ST_P10, ST_P11, ST_P12,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
        ST_H6, ST_H7, ST_H8, ST_H9, ST_H10,
        ST_FIN
    } step_t;

    typedef struct packed {
        step_t step;
        logic  load;
        logic  div_start;
    } cmd_t;

    typedef struct packed {
        logic third;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = a * b;
        return pr[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    function automatic logic [19:0] med3(input logic [19:0] a, input logic [19:0] b,
                                         input logic [19:0] c);
        logic [19:0] lo;
        logic [19:0] hi;
        logic [19:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

/* rtl/wsmc_div.sv */
`timescale 1ns / 1ps

module wsmc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [31:0] quot
);
    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [31:0] q_reg;
    logic [31:0] q_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [32:0] rem_sh;

    always_comb
    begin
        rem_sh   = {rem_reg[31:0], q_reg[31]};
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            q_next   = num;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                rem_next = rem_sh - {1'b0, den};
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign quot = q_reg;

endmodule

/* rtl/wsmc_datapath.sv */
`timescale 1ns / 1ps

module wsmc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wsmc_pkg::cmd_t                  cmd,
    output wsmc_pkg::status_t               status,
    input  logic                            cfg_valid,
    input  logic [wsmc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [wsmc_pkg::CfgDataW-1:0]   cfg_data,
    input  logic [19:0]                     raw_temperature,
    input  logic [19:0]                     raw_pressure,
    input  logic [15:0]                     raw_humidity,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              temperature_centi,
    output logic [31:0]                     pressure_pascal,
    output logic [16:0]                     humidity_q10,
    output logic                            out_of_range
);
    import wsmc_pkg::*;

    logic [47:0] tcal_reg;
    logic [47:0] pcal_a_reg;
    logic [47:0] pcal_b_reg;
    logic [47:0] pcal_c_reg;
    logic [63:0] hcal_reg;
    logic [1:0]  count_reg;
    logic        out_valid_reg;

    logic [19:0] held_t_reg [2];
    logic [19:0] held_p_reg [2];
    logic [15:0] held_h_reg [2];
    logic [19:0] mt_reg;
    logic [19:0] mp_reg;
    logic [15:0] mh_reg;

    logic [31:0] ta_reg, tb_reg, fine_reg, tval_reg;
    logic [31:0] v1_reg, v2_reg, qq_reg, w_reg, p_reg, pq_reg, pres_reg;
    logic        pz_reg, psmall_reg;
    logic [31:0] hv_reg, ha_reg, hb_reg, hc_reg;
    logic [16:0] hum_reg;

    logic signed [31:0] temp_reg;
    logic [31:0] pout_reg;
    logic [16:0] hout_reg;
    logic        bad_reg;

    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] quot;
    logic        div_busy;
    logic [31:0] div_num;
    logic [31:0] q_s;
    logic [31:0] hs;
    logic [31:0] hsum;
    logic        out_free;
    logic        bad;

    assign t1 = {16'd0, tcal_reg[15:0]};
    assign t2 = sx16(tcal_reg[31:16]);
    assign t3 = sx16(tcal_reg[47:32]);
    assign p1 = {16'd0, pcal_a_reg[15:0]};
    assign p2 = sx16(pcal_a_reg[31:16]);
    assign p3 = sx16(pcal_a_reg[47:32]);
    assign p4 = sx16(pcal_b_reg[15:0]);
    assign p5 = sx16(pcal_b_reg[31:16]);
    assign p6 = sx16(pcal_b_reg[47:32]);
    assign p7 = sx16(pcal_c_reg[15:0]);
    assign p8 = sx16(pcal_c_reg[31:16]);
    assign p9 = sx16(pcal_c_reg[47:32]);
    assign h1 = {24'd0, hcal_reg[7:0]};
    assign h2 = sx16(hcal_reg[23:8]);
    assign h3 = {24'd0, hcal_reg[31:24]};
    assign h4 = sx12(hcal_reg[43:32]);
    assign h5 = sx12(hcal_reg[55:44]);
    assign h6 = sx8(hcal_reg[63:56]);

    assign q_s      = asr(v1_reg, 2);
    assign hs       = asr(hv_reg, 15);
    assign div_num  = p_reg[31] ? p_reg : {p_reg[30:0], 1'b0};
    assign out_free = !out_valid_reg || out_ready;
    assign hsum     = hv_reg - asr(mul32(asr(hc_reg, 7), h1), 4);

    assign bad = (pres_reg < 32'd90000) || (pres_reg > 32'd110000) ||
                 (hum_reg < 17'd1024) || (hum_reg >= 17'd102400) ||
                 ($signed(tval_reg) < -32'sd2000) || ($signed(tval_reg) > 32'sd5000);

    wsmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (v1_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg      <= '0;
            pcal_a_reg    <= '0;
            pcal_b_reg    <= '0;
            pcal_c_reg    <= '0;
            hcal_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TEMP:  tcal_reg   <= cfg_data[47:0];
                    REG_PRS_A: pcal_a_reg <= cfg_data[47:0];
                    REG_PRS_B: pcal_b_reg <= cfg_data[47:0];
                    REG_PRS_C: pcal_c_reg <= cfg_data[47:0];
                    REG_HUM:   hcal_reg   <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.load)
            begin
                count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
            end
            if (cmd.step == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (count_reg == 2'd2)
            begin
                mt_reg <= med3(held_t_reg[0], held_t_reg[1], raw_temperature);
                mp_reg <= med3(held_p_reg[0], held_p_reg[1], raw_pressure);
                mh_reg <= 16'(med3({4'd0, held_h_reg[0]}, {4'd0, held_h_reg[1]},
                                   {4'd0, raw_humidity}));
            end
            else
            begin
                held_t_reg[count_reg[0]] <= raw_temperature;
                held_p_reg[count_reg[0]] <= raw_pressure;
                held_h_reg[count_reg[0]] <= raw_humidity;
            end
        end
        case (cmd.step)
            ST_T0:
            begin
                ta_reg <= {16'd0, mt_reg[19:4]} - t1;
                tb_reg <= {15'd0, mt_reg[19:3]} - {t1[30:0], 1'b0};
            end
            ST_T1:   tb_reg   <= asr(mul32(tb_reg, t2), 11);
            ST_T2:   ta_reg   <= asr(mul32(ta_reg, ta_reg), 12);
            ST_T3:   fine_reg <= tb_reg + asr(mul32(ta_reg, t3), 14);
            ST_T4:   tval_reg <= asr(mul32(fine_reg, 32'd5) + 32'd128, 8);
            ST_P0:   v1_reg   <= asr(fine_reg, 1) - 32'd64000;
            ST_P1:   qq_reg   <= mul32(q_s, q_s);
            ST_P2:   v2_reg   <= mul32(asr(qq_reg, 11), p6);
            ST_P3:
            begin
                v2_reg <= v2_reg + (mul32(v1_reg, p5) << 1);
            end
            ST_P4:
            begin
                v2_reg <= asr(v2_reg, 2) + {p4[15:0], 16'd0};
                w_reg  <= asr(mul32(p3, asr(qq_reg, 13)), 3);
            end
            ST_P5:   w_reg    <= asr(w_reg + asr(mul32(p2, v1_reg), 1), 18);
            ST_P6:   v1_reg   <= asr(mul32(32'd32768 + w_reg, p1), 15);
            ST_P7:
            begin
                pz_reg <= (v1_reg == 32'd0);
                p_reg  <= mul32((32'd1048576 - {12'd0, mp_reg}) - asr(v2_reg, 12),
                                32'd3125);
            end
            ST_P8:   psmall_reg <= !p_reg[31];
            ST_PQ:   p_reg    <= psmall_reg ? quot : {quot[30:0], 1'b0};
            ST_P9:   pq_reg   <= mul32({3'd0, p_reg[31:3]}, {3'd0, p_reg[31:3]});
            ST_P10:  v1_reg   <= asr(mul32(p9, {13'd0, pq_reg[31:13]}), 12);
            ST_P11:  v2_reg   <= asr(mul32({2'd0, p_reg[31:2]}, p8), 13);
            ST_P12:
            begin
                pres_reg <= pz_reg ? 32'd0 : p_reg + asr(v1_reg + v2_reg + p7, 4);
            end
            ST_H0:   hv_reg   <= fine_reg - 32'd76800;
            ST_H1:   ha_reg   <= mul32(h5, hv_reg);
            ST_H2:
            begin
                ha_reg <= asr({2'd0, mh_reg, 14'd0} - {h4[11:0], 20'd0} - ha_reg
                              + 32'd16384, 15);
            end
            ST_H3:   hb_reg   <= asr(mul32(hv_reg, h6), 10);
            ST_H4:   hc_reg   <= asr(mul32(hv_reg, h3), 11) + 32'd32768;
            ST_H5:   hb_reg   <= asr(mul32(hb_reg, hc_reg), 10) + 32'd2097152;
            ST_H6:   hb_reg   <= asr(mul32(hb_reg, h2) + 32'd8192, 14);
            ST_H7:   hv_reg   <= mul32(ha_reg, hb_reg);
            ST_H8:   hc_reg   <= mul32(hs, hs);
            ST_H9:   hv_reg   <= hsum;
            ST_H10:
            begin
                if (hv_reg[31])
                begin
                    hum_reg <= 17'd0;
                end
                else if (hv_reg > HUM_MAX)
                begin
                    hum_reg <= HUM_MAX[28:12];
                end
                else
                begin
                    hum_reg <= hv_reg[28:12];
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    temp_reg <= $signed(tval_reg);
                    pout_reg <= pres_reg;
                    hout_reg <= hum_reg;
                    bad_reg  <= bad;
                end
            end
            default: ;
        endcase
    end

    assign status.third    = (count_reg == 2'd2);
    assign status.div_busy = div_busy;
    assign status.out_free = out_free;

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign pressure_pascal   = pout_reg;
    assign humidity_q10      = hout_reg;
    assign out_of_range      = bad_reg;

endmodule

/* rtl/wsmc_ctrl.sv */
`timescale 1ns / 1ps

module wsmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wsmc_pkg::status_t status,
    output wsmc_pkg::cmd_t    cmd
);
    import wsmc_pkg::*;

    step_t state_reg;
    step_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && status.third) state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_T3;
            ST_T3:   state_next = ST_T4;
            ST_T4:   state_next = ST_P0;
            ST_P0:   state_next = ST_P1;
            ST_P1:   state_next = ST_P2;
            ST_P2:   state_next = ST_P3;
            ST_P3:   state_next = ST_P4;
            ST_P4:   state_next = ST_P5;
            ST_P5:   state_next = ST_P6;
            ST_P6:   state_next = ST_P7;
            ST_P7:   state_next = ST_P8;
            ST_P8:   state_next = ST_PDIV;
            ST_PDIV: if (!status.div_busy) state_next = ST_PQ;
            ST_PQ:   state_next = ST_P9;
            ST_P9:   state_next = ST_P10;
            ST_P10:  state_next = ST_P11;
            ST_P11:  state_next = ST_P12;
            ST_P12:  state_next = ST_H0;
            ST_H0:   state_next = ST_H1;
            ST_H1:   state_next = ST_H2;
            ST_H2:   state_next = ST_H3;
            ST_H3:   state_next = ST_H4;
            ST_H4:   state_next = ST_H5;
            ST_H5:   state_next = ST_H6;
            ST_H6:   state_next = ST_H7;
            ST_H7:   state_next = ST_H8;
            ST_H8:   state_next = ST_H9;
            ST_H9:   state_next = ST_H10;
            ST_H10:  state_next = ST_FIN;
            ST_FIN:  if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.step      = state_reg;
        cmd.load      = in_valid && (state_reg == ST_IDLE);
        cmd.div_start = (state_reg == ST_P8);
    end

endmodule

/* rtl/weather_sensor_median_compensation.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | raw_temperature, raw_pressure, raw_humidity
// out     | output    | out_valid / out_ready | temperature_centi, pressure_pascal,
//         |           |                       | humidity_q10, out_of_range
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The first two samples of a group are only stored. After the third is
// accepted in_ready stays low while the sequencer runs 31 steps with at most
// one 32x32 multiply each and waits on the bit-serial pressure divider.
// Reset is asynchronous, active low; calibration registers clear to zero.
// The next group is accepted while a result waits in the output register; a
// result still waiting when the next group finishes holds the last step.

module weather_sensor_median_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [19:0]                     raw_temperature,
    input  logic [19:0]                     raw_pressure,
    input  logic [15:0]                     raw_humidity,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              temperature_centi,
    output logic [31:0]                     pressure_pascal,
    output logic [16:0]                     humidity_q10,
    output logic                            out_of_range,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wsmc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [wsmc_pkg::CfgDataW-1:0]   cfg_data
);
    import wsmc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wsmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wsmc_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .raw_temperature   (raw_temperature),
        .raw_pressure      (raw_pressure),
        .raw_humidity      (raw_humidity),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temperature_centi (temperature_centi),
        .pressure_pascal   (pressure_pascal),
        .humidity_q10      (humidity_q10),
        .out_of_range      (out_of_range)
    );

endmodule

/* rtl/wsmc_checker.sv */
`timescale 1ns / 1ps

module wsmc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [31:0]              temperature_centi,
    input logic [31:0]                     pressure_pascal,
    input logic [16:0]                     humidity_q10,
    input logic                            out_of_range
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressure_pascal)
            && $stable(humidity_q10) && $stable(temperature_centi))
        else $error("result changed while stalled");

    a_hum_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity_q10 <= 17'd102400)
        else $error("humidity above clamp");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pressure_pascal == 32'd0 |-> out_of_range)
        else $error("zero pressure not flagged");

    a_low_hum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && humidity_q10 < 17'd1024 |-> out_of_range)
        else $error("low humidity not flagged");

endmodule

bind weather_sensor_median_compensation wsmc_checker u_chk (.*);
